>>> rtl/core/fwht_pkg.sv
// Shared types and constants for the frontmost window hit test block.
`timescale 1ns / 1ps
package fwht_pkg;

	localparam int MAX_WINDOWS_DEF = 64;
	localparam int IDX_W           = 6;
	localparam int DISP_W          = 16;
	localparam int COORD_W         = 32;
	localparam int ORDER_W         = 32;
	localparam int OUT_W           = 31;
	localparam int MIN_EXTENT      = 2;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]                opcode;
		logic [IDX_W-1:0]          entry_index;
		logic                      entry_used;
		logic [DISP_W-1:0]         display;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] rect_width;
		logic signed [COORD_W-1:0] rect_height;
		logic [ORDER_W-1:0]        stack_order;
		logic                      is_blocker;
	} fwht_in_t;

	typedef struct packed {
		logic             hit;
		logic [OUT_W-1:0] hit_x;
		logic [OUT_W-1:0] hit_y;
		logic [OUT_W-1:0] hit_width;
		logic [OUT_W-1:0] hit_height;
	} fwht_out_t;

	// record store word: valid flag, blocker flag, stacking order, display
	typedef struct packed {
		logic               used;
		logic               blocker;
		logic [ORDER_W-1:0] order;
		logic [DISP_W-1:0]  display;
	} fwht_rec_t;

	// geometry store word: origin and extent
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] h;
	} fwht_geo_t;

endpackage

>>> rtl/core/fwht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module fwht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/frontmost_window_hit_test_top.sv
// Top level of the frontmost window hit test: slot table, scan control and result register.
`timescale 1ns / 1ps
// Usage:
//   Command channel: cmd is taken at a rising edge with start high and busy low.
//   Opcodes: clear table, write one slot, query a point; an unused opcode is dropped.
//   Result channel: a query gives exactly one result, on result while done is high
//   for one cycle. The receiver cannot stall; the result is simply presented.
//   Write: busy stays low, no result.
//   Clear: busy while the record store walks every slot and drops its valid
//   flag, one slot a cycle; no result.
//   Query: the scan reads one slot a cycle from the record and geometry stores.
//   busy falls in the done cycle, so a new command is taken no earlier than the
//   done cycle of the last query; the single read port per store sets this.
//   Reset: arst_n low starts the same clearing pass as a clear command, so busy
//   stays high after reset is released until every slot is cleared.
//   Writes with an index at or beyond MAX_WINDOWS are ignored.
module frontmost_window_hit_test_top #(
	parameter int MAX_WINDOWS = fwht_pkg::MAX_WINDOWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fwht_pkg::fwht_in_t   cmd,
	output logic                 done,
	output fwht_pkg::fwht_out_t  result
);

	localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int RW = $bits(fwht_pkg::fwht_rec_t);
	localparam int GW = $bits(fwht_pkg::fwht_geo_t);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOWS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] addr_q;
	logic          accept;
	logic          in_range;

	logic [fwht_pkg::DISP_W-1:0]         disp_q;
	logic signed [fwht_pkg::COORD_W:0]   px_q;
	logic signed [fwht_pkg::COORD_W:0]   py_q;

	fwht_pkg::fwht_rec_t rec_wdata;
	fwht_pkg::fwht_rec_t rec_rdata;
	fwht_pkg::fwht_geo_t geo_wdata;
	fwht_pkg::fwht_geo_t geo_rdata;
	logic                rec_we;
	logic                geo_we;
	logic [AW-1:0]       waddr;

	logic v_s1, last_s1;
	logic v_s2, last_s2, ok_s2, blk_s2;
	logic signed [fwht_pkg::COORD_W:0] endx_s2, endy_s2;
	logic [fwht_pkg::ORDER_W-1:0]      order_s2;
	logic [fwht_pkg::OUT_W-1:0]        x_s2, y_s2, w_s2, h_s2;

	logic                         best_vld_q, best_blk_q;
	logic [fwht_pkg::ORDER_W-1:0] best_order_q;
	logic [fwht_pkg::OUT_W-1:0]   best_x_q, best_y_q, best_w_q, best_h_q;
	logic                         fin_q;
	logic                         match, take, s1_ok;

	logic                res_vld_q;
	fwht_pkg::fwht_out_t res_d;
	fwht_pkg::fwht_out_t res_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = (32'(cmd.entry_index) < MAX_WINDOWS);

	// store write port: clear pass or slot write
	always_comb begin
		rec_wdata         = '0;
		rec_wdata.used    = cmd.entry_used;
		rec_wdata.blocker = cmd.is_blocker;
		rec_wdata.order   = cmd.stack_order;
		rec_wdata.display = cmd.display;
		geo_wdata.x       = cmd.pos_x;
		geo_wdata.y       = cmd.pos_y;
		geo_wdata.w       = cmd.rect_width;
		geo_wdata.h       = cmd.rect_height;
		waddr             = AW'(cmd.entry_index);
		rec_we            = 1'b0;
		geo_we            = 1'b0;
		if (state_q == ST_CLEAR) begin
			rec_wdata = '0;
			waddr     = addr_q;
			rec_we    = 1'b1;
		end else if (accept && cmd.opcode == fwht_pkg::OP_WRITE && in_range) begin
			rec_we = 1'b1;
			geo_we = 1'b1;
		end
	end

	fwht_ram #(.WIDTH(RW), .DEPTH(MAX_WINDOWS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (waddr),
		.wdata (rec_wdata),
		.raddr (addr_q),
		.rdata (rec_rdata)
	);

	fwht_ram #(.WIDTH(GW), .DEPTH(MAX_WINDOWS)) u_geo_ram (
		.clk   (clk),
		.we    (geo_we),
		.waddr (waddr),
		.wdata (geo_wdata),
		.raddr (addr_q),
		.rdata (geo_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						case (cmd.opcode)
							fwht_pkg::OP_CLEAR: state_q <= ST_CLEAR;
							fwht_pkg::OP_QUERY: state_q <= ST_SCAN;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					v_s1    <= 1'b1;
					last_s1 <= (addr_q == LAST_ADDR);
					addr_q  <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (fin_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.opcode == fwht_pkg::OP_QUERY) begin
			disp_q <= cmd.display;
			px_q   <= {cmd.pos_x[fwht_pkg::COORD_W-1], cmd.pos_x};
			py_q   <= {cmd.pos_y[fwht_pkg::COORD_W-1], cmd.pos_y};
		end
	end

	// stage 2: slot filter and far edges at 33 bits
	assign s1_ok = rec_rdata.used && (rec_rdata.display == disp_q)
		&& (geo_rdata.w >= 32'(fwht_pkg::MIN_EXTENT))
		&& (geo_rdata.h >= 32'(fwht_pkg::MIN_EXTENT))
		&& !geo_rdata.x[fwht_pkg::COORD_W-1] && !geo_rdata.y[fwht_pkg::COORD_W-1]
		&& (px_q >= $signed({geo_rdata.x[fwht_pkg::COORD_W-1], geo_rdata.x}))
		&& (py_q >= $signed({geo_rdata.y[fwht_pkg::COORD_W-1], geo_rdata.y}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2    <= s1_ok;
		endx_s2  <= $signed({geo_rdata.x[fwht_pkg::COORD_W-1], geo_rdata.x})
			+ $signed({geo_rdata.w[fwht_pkg::COORD_W-1], geo_rdata.w});
		endy_s2  <= $signed({geo_rdata.y[fwht_pkg::COORD_W-1], geo_rdata.y})
			+ $signed({geo_rdata.h[fwht_pkg::COORD_W-1], geo_rdata.h});
		order_s2 <= rec_rdata.order;
		blk_s2   <= rec_rdata.blocker;
		x_s2     <= geo_rdata.x[fwht_pkg::OUT_W-1:0];
		y_s2     <= geo_rdata.y[fwht_pkg::OUT_W-1:0];
		w_s2     <= geo_rdata.w[fwht_pkg::OUT_W-1:0];
		h_s2     <= geo_rdata.h[fwht_pkg::OUT_W-1:0];
	end

	// stage 3: running frontmost pick, strict less keeps the lower index on a tie
	assign match = v_s2 && ok_s2 && (px_q < endx_s2) && (py_q < endy_s2);
	assign take  = match && (!best_vld_q || (order_s2 < best_order_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
			fin_q      <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			fin_q     <= v_s2 && last_s2;
			res_vld_q <= fin_q;
			if (accept && cmd.opcode == fwht_pkg::OP_QUERY) begin
				best_vld_q <= 1'b0;
			end else if (take) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_comb begin
		res_d = '0;
		if (best_vld_q && !best_blk_q) begin
			res_d.hit        = 1'b1;
			res_d.hit_x      = best_x_q;
			res_d.hit_y      = best_y_q;
			res_d.hit_width  = best_w_q;
			res_d.hit_height = best_h_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_order_q <= order_s2;
			best_blk_q   <= blk_s2;
			best_x_q     <= x_s2;
			best_y_q     <= y_s2;
			best_w_q     <= w_s2;
			best_h_q     <= h_s2;
		end
		if (fin_q) begin
			res_q <= res_d;
		end
	end

	assign done   = res_vld_q;
	assign result = res_q;

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.hit_x == '0 && result.hit_y == '0
			&& result.hit_width == '0 && result.hit_height == '0)
		else $error("miss result carries nonzero fields");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode == fwht_pkg::OP_QUERY |=> busy && !done)
		else $error("query accepted without starting a scan");

	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DRAIN)
		else $error("result strobe outside scan end");

endmodule

>>> sim/frontmost_window_hit_test_top_tb.sv
// Self-checking testbench for the frontmost window hit test: random scenes and queries vs. a local slot table.
`timescale 1ns / 1ps
module frontmost_window_hit_test_top_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RAND_BEATS = 1400;
	localparam int END_DRAIN = 200;
	localparam int MAX_PRINT = 100;

	typedef struct {
		fwht_pkg::fwht_in_t beat;
		int unsigned        gap;
	} pending_t;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	logic                busy;
	fwht_pkg::fwht_in_t  cmd    = '0;
	logic                done;
	fwht_pkg::fwht_out_t result;

	pending_t            pending [$];
	fwht_pkg::fwht_out_t hit_expect [$];
	fwht_pkg::fwht_rec_t slot_rec [fwht_pkg::MAX_WINDOWS_DEF];
	fwht_pkg::fwht_geo_t slot_geo [fwht_pkg::MAX_WINDOWS_DEF];
	int unsigned accept_cnt = 0;
	int unsigned issued_cnt = 0;
	int unsigned idle_left = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned queued_cnt = 0;
	logic        have_next = 1'b0;
	fwht_pkg::fwht_in_t next_beat = '0;

	frontmost_window_hit_test_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINT)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	function automatic fwht_pkg::fwht_out_t find_frontmost(input fwht_pkg::fwht_in_t q);
		int best;
		fwht_pkg::fwht_out_t r;
		best = -1;
		r = '0;
		for (int i = 0; i < fwht_pkg::MAX_WINDOWS_DEF; i++) begin
			if (!slot_rec[i].used || slot_rec[i].display != q.display)
				continue;
			if ($signed(slot_geo[i].w) < fwht_pkg::MIN_EXTENT
					|| $signed(slot_geo[i].h) < fwht_pkg::MIN_EXTENT)
				continue;
			if ($signed(slot_geo[i].x) < 0 || $signed(slot_geo[i].y) < 0)
				continue;
			if ($signed(q.pos_x) < $signed(slot_geo[i].x)
					|| $signed(q.pos_y) < $signed(slot_geo[i].y))
				continue;
			if (longint'($signed(q.pos_x)) >=
					longint'($signed(slot_geo[i].x)) + longint'($signed(slot_geo[i].w)))
				continue;
			if (longint'($signed(q.pos_y)) >=
					longint'($signed(slot_geo[i].y)) + longint'($signed(slot_geo[i].h)))
				continue;
			if (best < 0 || slot_rec[i].order < slot_rec[best].order)
				best = i;
		end
		if (best >= 0 && !slot_rec[best].blocker) begin
			r.hit        = 1'b1;
			r.hit_x      = slot_geo[best].x[fwht_pkg::OUT_W-1:0];
			r.hit_y      = slot_geo[best].y[fwht_pkg::OUT_W-1:0];
			r.hit_width  = slot_geo[best].w[fwht_pkg::OUT_W-1:0];
			r.hit_height = slot_geo[best].h[fwht_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	function automatic fwht_pkg::fwht_in_t make_beat(input logic [1:0] op,
			input int unsigned idx, input int used, input int unsigned disp,
			input int x, input int y, input int w, input int h,
			input int unsigned order, input int blk);
		fwht_pkg::fwht_in_t b;
		b.opcode      = op;
		b.entry_index = idx[fwht_pkg::IDX_W-1:0];
		b.entry_used  = used[0];
		b.display     = disp[fwht_pkg::DISP_W-1:0];
		b.pos_x       = x;
		b.pos_y       = y;
		b.rect_width  = w;
		b.rect_height = h;
		b.stack_order = order;
		b.is_blocker  = blk[0];
		return b;
	endfunction

	function automatic fwht_pkg::fwht_in_t rand_beat(input logic [1:0] op);
		return make_beat(op, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
	endfunction

	function automatic int edge_extent();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return -1;
			4: return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	task automatic add_beat(input fwht_pkg::fwht_in_t b);
		pending_t p;
		int unsigned r;
		r = $urandom_range(0, 99);
		p.beat = b;
		if ((queued_cnt / 150) % 4 == 3 || r < 60)
			p.gap = 0;
		else if (r < 85)
			p.gap = $urandom_range(1, 3);
		else if (r < 97)
			p.gap = $urandom_range(4, 12);
		else
			p.gap = $urandom_range(20, 100);
		pending.push_back(p);
		queued_cnt++;
	endtask

	// driver: one beat held on cmd until taken, random idle between beats
	always @(negedge clk) begin
		pending_t p;
		if (arst_n) begin
			if (start && accept_cnt != issued_cnt) begin
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (have_next) begin
				cmd <= next_beat;
				start <= 1'b1;
				issued_cnt <= issued_cnt + 1;
				have_next <= 1'b0;
			end else if (pending.size() != 0) begin
				p = pending.pop_front();
				if (p.gap == 0) begin
					cmd <= p.beat;
					start <= 1'b1;
					issued_cnt <= issued_cnt + 1;
				end else begin
					next_beat <= p.beat;
					have_next <= 1'b1;
					idle_left <= p.gap - 1;
					start <= 1'b0;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, then update the local table on each taken beat
	always @(posedge clk) begin
		fwht_pkg::fwht_out_t want;
		if (arst_n) begin
			if (done) begin
				if (hit_expect.size() == 0) begin
					report_mismatch("unexpected result", 32'(result.hit), 32'd0);
				end else begin
					want = hit_expect.pop_front();
					if (result.hit !== want.hit)
						report_mismatch("hit", 32'(result.hit), 32'(want.hit));
					if (result.hit_x !== want.hit_x)
						report_mismatch("hit_x", 32'(result.hit_x), 32'(want.hit_x));
					if (result.hit_y !== want.hit_y)
						report_mismatch("hit_y", 32'(result.hit_y), 32'(want.hit_y));
					if (result.hit_width !== want.hit_width)
						report_mismatch("hit_width", 32'(result.hit_width),
							32'(want.hit_width));
					if (result.hit_height !== want.hit_height)
						report_mismatch("hit_height", 32'(result.hit_height),
							32'(want.hit_height));
				end
			end
			if (start && !busy) begin
				case (cmd.opcode)
					fwht_pkg::OP_CLEAR: begin
						for (int i = 0; i < fwht_pkg::MAX_WINDOWS_DEF; i++)
							slot_rec[i].used = 1'b0;
					end
					fwht_pkg::OP_WRITE: begin
						if (cmd.entry_index < fwht_pkg::MAX_WINDOWS_DEF) begin
							slot_rec[cmd.entry_index] = '{cmd.entry_used, cmd.is_blocker,
								cmd.stack_order, cmd.display};
							slot_geo[cmd.entry_index] = '{cmd.pos_x, cmd.pos_y,
								cmd.rect_width, cmd.rect_height};
						end
					end
					fwht_pkg::OP_QUERY: hit_expect.push_back(find_frontmost(cmd));
					default: ;
				endcase
				accept_cnt <= accept_cnt + 1;
			end
		end
	end

	initial begin
		int unsigned counted;
		int unsigned r;
		fwht_pkg::fwht_in_t b;

		for (int i = 0; i < fwht_pkg::MAX_WINDOWS_DEF; i++) begin
			slot_rec[i] = '0;
			slot_geo[i] = '0;
		end

		// directed: edges, ties, blocker, unusable slots, extreme coordinates
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_WRITE, 0, 1, 0, 0, 0, 2, 2, 5, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 1, 1, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 2, 1, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 1, 2, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, -1, 0, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_WRITE, 1, 1, 0, 0, 0, 10, 10, 5, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_WRITE, 2, 1, 0, 0, 0, 10, 10, 1, 1));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 5, 5, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_WRITE, 2, 0, 0, 0, 0, 10, 10, 1, 1));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 5, 5, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_WRITE, 3, 1, 0, 0, 0, 1, 10, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_WRITE, 4, 1, 0, -5, 0, 100, 100, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_WRITE, 63, 1, 16'hFFFF, 32'h7FFF_FFF0,
			32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 16'hFFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			0, 0, 0, 0));
		add_beat(rand_beat(OP_UNUSED));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 3, 3, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_beat(make_beat(fwht_pkg::OP_QUERY, 0, 0, 16'hFFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0, 0, 0, 0));

		// random: small dense scenes on a few displays, with some wild beats
		counted = 0;
		while (counted < RAND_BEATS) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				add_beat(rand_beat(fwht_pkg::OP_CLEAR));
				counted++;
			end else if (r < 5) begin
				add_beat(rand_beat(OP_UNUSED));
			end else if (r < 50) begin
				b = rand_beat(fwht_pkg::OP_WRITE);
				r = $urandom_range(0, 99);
				if (r < 80) begin
					b.display     = 16'($urandom_range(0, 3));
					b.pos_x       = $urandom_range(0, 255);
					b.pos_y       = $urandom_range(0, 255);
					b.rect_width  = $urandom_range(0, 160);
					b.rect_height = $urandom_range(0, 160);
					b.stack_order = $urandom_range(0, 15);
				end else if (r < 90) begin
					b.display     = 16'($urandom_range(0, 3));
					b.pos_x       = $urandom_range(0, 1) ? -$urandom_range(1, 50)
						: $urandom_range(0, 255);
					b.pos_y       = $urandom_range(0, 255);
					b.rect_width  = edge_extent();
					b.rect_height = $urandom_range(0, 1) ? edge_extent()
						: $urandom_range(2, 160);
				end
				b.entry_used = ($urandom_range(0, 9) != 0);
				b.is_blocker = ($urandom_range(0, 4) == 0);
				add_beat(b);
				counted++;
			end else begin
				b = rand_beat(fwht_pkg::OP_QUERY);
				if ($urandom_range(0, 99) < 85) begin
					b.display = 16'($urandom_range(0, 3));
					b.pos_x   = $urandom_range(0, 400);
					b.pos_y   = $urandom_range(0, 400);
				end
				add_beat(b);
				counted++;
			end
		end

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || have_next || idle_left != 0 || accept_cnt != issued_cnt)
			@(posedge clk);
		while (hit_expect.size() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);
		if (mismatch_cnt == 0 && hit_expect.size() == 0)
			$display("PASS frontmost_window_hit_test_top");
		else
			$display("FAIL frontmost_window_hit_test_top");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("FAIL frontmost_window_hit_test_top");
		$finish;
	end

endmodule
